// ----- sv/bitmap_text_page_renderer_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap text page renderer
// Shared immediate-implication and next-cycle checks on one clock and reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_TEXT_PAGE_RENDERER_UNIT_DEFINES_SVH
`define BITMAP_TEXT_PAGE_RENDERER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTPR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("btpr check failed");

// The consequent must hold in the cycle after the antecedent.
`define BTPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("btpr check failed");

`endif

// ----- sv/btpr_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap text page renderer package
// Commands, register indexes, configuration and queue entry types.
// ----------------------------------------------------------------------------
package btpr_pkg;

  // Input commands.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_CHAR  = 2'd1;
  localparam logic [1:0] CMD_LOAD  = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // Configuration register indexes.
  localparam logic [2:0] REG_FIRST_CHAR   = 3'd0;
  localparam logic [2:0] REG_CHAR_COUNT   = 3'd1;
  localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd2;
  localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd3;
  localparam logic [2:0] REG_CHAR_SPACING = 3'd4;
  localparam logic [2:0] REG_LINE_SPACING = 3'd5;
  localparam logic [2:0] REG_WRAP_ENABLE  = 3'd6;
  localparam logic [2:0] REG_PIXEL_STATE  = 3'd7;

  // Job queue depth between front and back end.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // Width of the raw font address before reduction modulo the memory size.
  localparam int RED_W = 17;

  typedef struct packed {
    logic [7:0] first_char;
    logic [7:0] char_count;
    logic [3:0] glyph_width;
    logic [5:0] glyph_height;
    logic [7:0] char_spacing;
    logic [7:0] line_spacing;
    logic       wrap_enable;
    logic [1:0] pixel_state;
  } cfg_t;

  // One job for the back end: a font byte load or a glyph draw.
  typedef struct packed {
    logic        is_load;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  idx;
    logic [3:0]  weff;
    logic [2:0]  pages;
    logic [12:0] addr;
    logic [7:0]  value;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

// ----- sv/btpr_if.sv -----
// ----------------------------------------------------------------------------
// Bitmap text page renderer channel interfaces
// Input item channel and page write result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface btpr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic [7:0]         char_code;
  logic [12:0]        font_address;
  logic [7:0]         font_value;

  modport source (output valid, command, start_x, start_y, char_code, font_address,
                  font_value, input ready);
  modport sink (input valid, command, start_x, start_y, char_code, font_address,
                font_value, output ready);
endinterface

interface btpr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] page_x;
  logic signed [15:0] page_y;
  logic [7:0]         page_bits;
  logic [1:0]         draw_mode;
  logic               last;

  modport source (output valid, page_x, page_y, page_bits, draw_mode, last, input ready);
  modport sink (input valid, page_x, page_y, page_bits, draw_mode, last, output ready);
endinterface

// ----- sv/btpr_front.sv -----
// ----------------------------------------------------------------------------
// Bitmap text page renderer front end
// Accepts items, keeps the cursor and origin, and queues load and draw jobs.
// ----------------------------------------------------------------------------
module btpr_front #(
  parameter int FRAME_WIDTH     = 128,
  parameter int MAX_GLYPH_WIDTH = 8,
  parameter int MAX_PAGES       = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  btpr_pkg::cfg_t    cfg,
  btpr_in_if.sink           in_ch,
  input  btpr_pkg::q_stat_t q_stat,
  output logic              q_push,
  output btpr_pkg::q_entry_t q_data
);
  import btpr_pkg::*;

  logic [15:0] cursor_x_r, cursor_x_nxt;
  logic [15:0] cursor_y_r, cursor_y_nxt;
  logic [15:0] origin_x_r, origin_x_nxt;

  logic        accept;
  logic [3:0]  weff;
  logic [5:0]  heff;
  logic [2:0]  pages;
  logic [7:0]  end_code;
  logic        in_range;
  logic [16:0] wrap_sum;
  logic        wrap_hit;
  logic [15:0] line_y;
  logic [15:0] x0;
  logic [15:0] y0;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Effective glyph size after clamping to the supported maximum.
  always_comb begin
    weff = cfg.glyph_width;
    if ({1'b0, cfg.glyph_width} > 5'(MAX_GLYPH_WIDTH)) begin
      weff = 4'(MAX_GLYPH_WIDTH);
    end
    heff = cfg.glyph_height;
    if (cfg.glyph_height > 6'(MAX_PAGES * 8)) begin
      heff = 6'(MAX_PAGES * 8);
    end
  end

  assign pages    = 3'(({1'b0, heff} + 7'd7) >> 3);
  assign end_code = cfg.first_char + cfg.char_count;
  assign in_range = (in_ch.char_code >= cfg.first_char) && (in_ch.char_code < end_code);
  assign line_y   = cursor_y_r + 16'(heff) + 16'(cfg.line_spacing);

  // Wrap check on the signed cursor column.
  assign wrap_sum = {cursor_x_r[15], cursor_x_r} + 17'(weff);
  assign wrap_hit = cfg.wrap_enable && ($signed(wrap_sum) > $signed(17'(FRAME_WIDTH)));
  assign x0       = wrap_hit ? origin_x_r : cursor_x_r;
  assign y0       = wrap_hit ? line_y : cursor_y_r;

  // Cursor update and job selection.
  always_comb begin
    cursor_x_nxt   = cursor_x_r;
    cursor_y_nxt   = cursor_y_r;
    origin_x_nxt   = origin_x_r;
    q_push         = 1'b0;
    q_data.is_load = 1'b0;
    q_data.x       = x0;
    q_data.y       = y0;
    q_data.idx     = in_ch.char_code - cfg.first_char;
    q_data.weff    = weff;
    q_data.pages   = pages;
    q_data.addr    = in_ch.font_address;
    q_data.value   = in_ch.font_value;
    if (accept) begin
      case (in_ch.command)
        CMD_START: begin
          origin_x_nxt = in_ch.start_x;
          cursor_x_nxt = in_ch.start_x;
          cursor_y_nxt = in_ch.start_y;
        end
        CMD_CHAR: begin
          if (in_ch.char_code == NEWLINE_CODE) begin
            cursor_x_nxt = origin_x_r;
            cursor_y_nxt = line_y;
          end else begin
            cursor_x_nxt = x0 + 16'(weff) + 16'(cfg.char_spacing);
            cursor_y_nxt = y0;
            q_push       = in_range && (weff != 4'd0) && (pages != 3'd0);
          end
        end
        CMD_LOAD: begin
          q_push         = 1'b1;
          q_data.is_load = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      origin_x_r <= '0;
    end else begin
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      origin_x_r <= origin_x_nxt;
    end
  end

endmodule

// ----- sv/btpr_fifo.sv -----
// ----------------------------------------------------------------------------
// Bitmap text page renderer job queue
// Short first-in first-out queue that decouples front and back end.
// ----------------------------------------------------------------------------
module btpr_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  btpr_pkg::q_entry_t push_data,
  input  logic               pop,
  output btpr_pkg::q_entry_t pop_data,
  output btpr_pkg::q_stat_t  stat
);
  import btpr_pkg::*;

  q_entry_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign stat.full  = (count_r == (Q_AW + 1)'(Q_DEPTH));
  assign stat.valid = (count_r != '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ----- sv/btpr_back.sv -----
// ----------------------------------------------------------------------------
// Bitmap text page renderer back end
// Owns font memory, executes load and draw jobs, and emits page writes.
// ----------------------------------------------------------------------------
`include "bitmap_text_page_renderer_unit_defines.svh"

module btpr_back #(
  parameter int FONT_BYTES = 8192
) (
  input  logic               clk,
  input  logic               rst_n,
  input  btpr_pkg::cfg_t     cfg,
  input  btpr_pkg::q_stat_t  q_stat,
  input  btpr_pkg::q_entry_t q_data,
  output logic               q_pop,
  btpr_out_if.source         out_ch
);
  import btpr_pkg::*;

  localparam int AW = $clog2(FONT_BYTES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BASE = 3'd1;
  localparam logic [2:0] ST_MOD  = 3'd2;
  localparam logic [2:0] ST_RUN  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [7:0]  font_mem [FONT_BYTES];

  logic [2:0]       state_r;
  logic             is_load_r;
  logic [7:0]       idx_r;
  logic [5:0]       wp_r;
  logic [2:0]       pages_r;
  logic [15:0]      cx_r;
  logic [15:0]      cy_r;
  logic [7:0]       val_r;
  logic [RED_W-1:0] red_r;
  logic [AW-1:0]    addr_r;
  logic [5:0]       remain_r;
  logic [3:0]       col_r;
  logic [1:0]       pg_r;

  // Byte read from font memory and its page coordinates.
  logic             dv_r;
  logic [7:0]       rd_r;
  logic [15:0]      dx_r;
  logic [15:0]      dy_r;

  // Held nonzero byte, sent once the next one or the end is known.
  logic             has_pend_r;
  logic [7:0]       pend_bits_r;
  logic [15:0]      pend_x_r;
  logic [15:0]      pend_y_r;

  logic             out_valid_r;
  logic [15:0]      out_x_r;
  logic [15:0]      out_y_r;
  logic [7:0]       out_bits_r;
  logic [1:0]       out_mode_r;
  logic             out_last_r;

  logic slot_free;
  logic data_nz;
  logic consume;
  logic issue;
  logic mem_we;
  logic emit;
  logic emit_last;
  logic red_big;
  logic pg_end;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign data_nz   = (rd_r != 8'd0);
  assign consume   = (state_r == ST_RUN) && dv_r && (!data_nz || !has_pend_r || slot_free);
  assign issue     = (state_r == ST_RUN) && (remain_r != '0) && (!dv_r || consume);
  assign q_pop     = (state_r == ST_IDLE) && q_stat.valid;
  assign red_big   = (red_r >= RED_W'(FONT_BYTES));
  assign mem_we    = (state_r == ST_MOD) && !red_big && is_load_r;
  assign pg_end    = ({1'b0, pg_r} == (pages_r - 3'd1));
  assign emit      = (consume && data_nz && has_pend_r) ||
                     ((state_r == ST_FIN) && has_pend_r && slot_free);
  assign emit_last = (state_r == ST_FIN);

  // Font memory: one write port for loads, one registered read for drawing.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      font_mem[red_r[AW-1:0]] <= val_r;
    end
    if (issue) begin
      rd_r <= font_mem[addr_r];
      dx_r <= cx_r + 16'(col_r);
      dy_r <= cy_r + {11'd0, pg_r, 3'd0};
    end
  end

  // Job sequencer and address walk.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      dv_r       <= 1'b0;
      has_pend_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (q_stat.valid) begin
            is_load_r <= q_data.is_load;
            idx_r     <= q_data.idx;
            wp_r      <= 6'(q_data.weff * q_data.pages);
            pages_r   <= q_data.pages;
            cx_r      <= q_data.x;
            cy_r      <= q_data.y;
            val_r     <= q_data.value;
            red_r     <= RED_W'(q_data.addr);
            state_r   <= q_data.is_load ? ST_MOD : ST_BASE;
          end
        end
        ST_BASE: begin
          red_r    <= RED_W'(idx_r * wp_r);
          remain_r <= wp_r;
          col_r    <= '0;
          pg_r     <= '0;
          state_r  <= ST_MOD;
        end
        ST_MOD: begin
          // Reduce the raw address modulo the memory size, one subtract a cycle.
          if (red_big) begin
            red_r <= red_r - RED_W'(FONT_BYTES);
          end else begin
            addr_r  <= red_r[AW-1:0];
            state_r <= is_load_r ? ST_IDLE : ST_RUN;
          end
        end
        ST_RUN: begin
          if (issue) begin
            dv_r     <= 1'b1;
            remain_r <= remain_r - 6'd1;
            addr_r   <= (addr_r == AW'(FONT_BYTES - 1)) ? '0 : addr_r + 1'b1;
            if (pg_end) begin
              pg_r  <= '0;
              col_r <= col_r + 4'd1;
            end else begin
              pg_r <= pg_r + 2'd1;
            end
          end else if (consume) begin
            dv_r <= 1'b0;
          end
          if (consume && data_nz) begin
            has_pend_r  <= 1'b1;
            pend_bits_r <= rd_r;
            pend_x_r    <= dx_r;
            pend_y_r    <= dy_r;
          end
          if ((remain_r == '0) && (!dv_r || consume)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!has_pend_r) begin
            state_r <= ST_IDLE;
          end else if (slot_free) begin
            has_pend_r <= 1'b0;
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_r    <= pend_x_r;
      out_y_r    <= pend_y_r;
      out_bits_r <= pend_bits_r;
      out_mode_r <= cfg.pixel_state;
      out_last_r <= emit_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.page_x    = out_x_r;
  assign out_ch.page_y    = out_y_r;
  assign out_ch.page_bits = out_bits_r;
  assign out_ch.draw_mode = out_mode_r;
  assign out_ch.last      = out_last_r;

  // Checks on the sequencer and result path.
  `BTPR_ASSERT_SAME(a_bits_nonzero, clk, rst_n, out_valid_r, out_bits_r != 8'd0)
  `BTPR_ASSERT_SAME(a_idle_no_pend, clk, rst_n, state_r == ST_IDLE, !has_pend_r)
  `BTPR_ASSERT_SAME(a_data_in_run, clk, rst_n, dv_r, state_r == ST_RUN)
  `BTPR_ASSERT_NEXT(a_final_sent, clk, rst_n,
                    (state_r == ST_FIN) && has_pend_r && slot_free,
                    out_valid_r && out_last_r && (state_r == ST_IDLE))

endmodule

// ----- sv/bitmap_text_page_renderer_unit.sv -----
// ----------------------------------------------------------------------------
// Bitmap text page renderer
// Character codes in, page writes for a paged monochrome framebuffer out.
// ----------------------------------------------------------------------------
//   channel  direction  handshake         carries
//   in_ch    in         valid/ready       command, origin, code, font byte
//   out_ch   out        valid/ready       page column, row, bits, mode, last
//   cfg_*    in         write enable only register index and value
//
// Start items, newlines and undrawn characters queue no job for the back end.
// A load reduces its address modulo the font size, then writes the font byte;
// a drawn glyph reads width * pages bytes, one font byte per cycle through the
// single font memory read port while the output is not stalled. A four-entry
// job queue lets the front end run ahead. Font memory is undefined after reset
// and is not cleared; cursor, origin and configuration reset at once. A stalled
// output holds the back end but not the front end until the queue fills.
// ----------------------------------------------------------------------------
module bitmap_text_page_renderer_unit #(
  parameter int FONT_BYTES      = 8192,
  parameter int FRAME_WIDTH     = 128,
  parameter int MAX_GLYPH_WIDTH = 8,
  parameter int MAX_PAGES       = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  btpr_in_if.sink    in_ch,
  btpr_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import btpr_pkg::*;

  cfg_t     cfg_r;
  q_stat_t  q_stat;
  q_entry_t push_data;
  q_entry_t pop_data;
  logic     q_push;
  logic     q_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_char   <= 8'd32;
      cfg_r.char_count   <= 8'd96;
      cfg_r.glyph_width  <= 4'd5;
      cfg_r.glyph_height <= 6'd8;
      cfg_r.char_spacing <= 8'd1;
      cfg_r.line_spacing <= 8'd0;
      cfg_r.wrap_enable  <= 1'b1;
      cfg_r.pixel_state  <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_CHAR:   cfg_r.first_char   <= cfg_wdata;
        REG_CHAR_COUNT:   cfg_r.char_count   <= cfg_wdata;
        REG_GLYPH_WIDTH:  cfg_r.glyph_width  <= cfg_wdata[3:0];
        REG_GLYPH_HEIGHT: cfg_r.glyph_height <= cfg_wdata[5:0];
        REG_CHAR_SPACING: cfg_r.char_spacing <= cfg_wdata;
        REG_LINE_SPACING: cfg_r.line_spacing <= cfg_wdata;
        REG_WRAP_ENABLE:  cfg_r.wrap_enable  <= cfg_wdata[0];
        REG_PIXEL_STATE:  cfg_r.pixel_state  <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  btpr_front #(
    .FRAME_WIDTH     (FRAME_WIDTH),
    .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH),
    .MAX_PAGES       (MAX_PAGES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (push_data)
  );

  btpr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  btpr_back #(
    .FONT_BYTES (FONT_BYTES)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_stat (q_stat),
    .q_data (pop_data),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
